// ===== rtl/dmkr_pkg.sv =====
`default_nettype none
package dmkr_pkg;

   localparam int TRIAL_W = 8;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_DONE
   } state_type;

   typedef logic [1:64] blk64_type;

   // Input bit number (1 = MSB) feeding each output bit of the fixed permutations
   localparam byte unsigned IP_T [64] = '{
      58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
      62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
      57,49,41,33,25,17,9,1, 59,51,43,35,27,19,11,3,
      61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
   localparam byte unsigned FP_T [64] = '{
      40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
      38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
      36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
      34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
   localparam byte unsigned E_T [48] = '{
      32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
      16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
   localparam byte unsigned P_T [32] = '{
      16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
      2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
   localparam byte unsigned PC1_T [56] = '{
      57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
      10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
      63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
      14,6,61,53,45,37,29, 21,13,5,28,20,12,4};
   localparam byte unsigned PC2_T [48] = '{
      14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
      41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53, 46,42,50,36,29,32};
   // Rounds with a single-bit rotation (1,2,9,16 counted from 1)
   localparam logic [15:0] ROT1_T = 16'b1000_0001_0000_0011;
   localparam byte unsigned GAP_T [8] = '{14, 15, 19, 20, 51, 54, 58, 60};

   localparam logic [3:0] SBOX_T [8][64] = '{
      '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
        4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
      '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
        0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
      '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
        13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
      '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
        10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
      '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
        4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
      '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
        9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
      '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
        1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
      '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
        7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

   // DES round function: R and the 48-bit round key in, f(R, K) out
   function automatic logic [1:32] des_f(input logic [1:32] r, input logic [1:48] k);
      logic [1:48] x;
      logic [1:32] s;
      logic [1:32] o;
      logic [5:0]  six;
      for (int i = 0; i < 48; i++) x[i+1] = r[E_T[i]] ^ k[i+1];
      for (int b = 0; b < 8; b++) begin
         six = x[6*b+1 +: 6];
         s[4*b+1 +: 4] = SBOX_T[b][{six[5], six[0], six[4:1]}];
      end
      for (int i = 0; i < 32; i++) o[i+1] = s[P_T[i]];
      return o;
   endfunction

   function automatic logic [1:48] pc2(input logic [1:56] cd);
      logic [1:48] k;
      for (int i = 0; i < 48; i++) k[i+1] = cd[PC2_T[i]];
      return k;
   endfunction

   function automatic logic [1:56] pc1(input logic [1:64] key);
      logic [1:56] cd;
      for (int i = 0; i < 56; i++) cd[i+1] = key[PC1_T[i]];
      return cd;
   endfunction

   function automatic logic [1:64] ip(input logic [1:64] v);
      logic [1:64] o;
      for (int i = 0; i < 64; i++) o[i+1] = v[IP_T[i]];
      return o;
   endfunction

   function automatic logic [1:64] fp(input logic [1:64] v);
      logic [1:64] o;
      for (int i = 0; i < 64; i++) o[i+1] = v[FP_T[i]];
      return o;
   endfunction

   // Subkey bits back to key positions; missing and parity bits zero
   function automatic logic [1:64] base_key(input logic [1:48] sub);
      logic [1:64] k;
      k = '0;
      for (int j = 0; j < 48; j++) k[PC1_T[PC2_T[j]-1]] = sub[j+1];
      return k;
   endfunction

   function automatic logic [1:64] with_trial(input logic [1:64] base,
                                              input logic [TRIAL_W-1:0] m);
      logic [1:64] k;
      k = base;
      for (int i = 0; i < 8; i++) k[GAP_T[i]] = m[i];
      return k;
   endfunction

   function automatic logic [1:64] odd_par(input logic [1:64] k);
      logic [1:64] o;
      o = k;
      for (int b = 0; b < 8; b++) o[8*b+8] = ~(^k[8*b+1 +: 7]);
      return o;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/dmkr_round.sv =====
`default_nettype none
module dmkr_round
   import dmkr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        load,
   input  wire logic [1:64] key,
   input  wire logic [1:64] plaintext,
   input  wire logic [3:0]  round_idx,
   output logic [1:64]      cipher
);

   logic [1:28] c_ff, c_in, d_ff, d_in;
   logic [1:32] l_ff, l_in, r_ff, r_in;
   logic [1:56] cd0;
   logic [1:64] blk;
   logic [1:28] c_src, d_src;
   logic [1:32] l_src, r_src;
   logic        one;

   // Shared round unit: load applies round 1, later cycles apply rounds 2..16
   always_comb begin
      cd0   = pc1(key);
      blk   = ip(plaintext);
      c_src = load ? cd0[1:28]  : c_ff;
      d_src = load ? cd0[29:56] : d_ff;
      l_src = load ? blk[1:32]  : l_ff;
      r_src = load ? blk[33:64] : r_ff;
      one   = ROT1_T[round_idx];
      c_in  = one ? {c_src[2:28], c_src[1]} : {c_src[3:28], c_src[1:2]};
      d_in  = one ? {d_src[2:28], d_src[1]} : {d_src[3:28], d_src[1:2]};
      l_in  = r_src;
      r_in  = l_src ^ des_f(r_src, pc2({c_in, d_in}));
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in;
      d_ff <= d_in;
      l_ff <= l_in;
      r_ff <= r_in;
   end

   assign cipher = fp({r_ff, l_ff});

endmodule
`default_nettype wire

// ===== rtl/des_master_key_recovery_top.sv =====
`default_nettype none
// Recovers a DES key from a known plaintext/ciphertext pair and the
// round-16 subkey. The subkey fills 48 key bits; the 8 missing bits are
// searched from trial 0 upward with one shared DES round unit, one round per
// cycle; each trial is 16 rounds plus a compare, and the search stops at the
// first hit or after trial 255 when nothing matches. The input stalls for the
// whole search; a finished key waits in DONE while the previous result beat
// is still stalled.
module des_master_key_recovery_top
   import dmkr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [63:0] req_plaintext,
   input  wire logic [63:0] req_ciphertext,
   input  wire logic [47:0] req_round_subkey,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      rsp_full_key,
   output logic             rsp_found
);

   state_type           state_ff, state_in;
   logic [1:64]         pt_ff, pt_in, ct_ff, ct_in, base_ff, base_in;
   logic [TRIAL_W-1:0]  trial_ff, trial_in;
   logic [3:0]          rnd_ff, rnd_in;
   logic                hit_ff, hit_in;
   logic                ovalid_ff, ovalid_in;
   logic [63:0]         okey_ff, okey_in;
   logic                ofound_ff, ofound_in;
   logic                load;
   logic [1:64]         cand, cipher;

   assign cand = with_trial(base_ff, trial_ff);

   dmkr_round u_round (
      .clock     (clock),
      .load      (load),
      .key       (cand),
      .plaintext (pt_ff),
      .round_idx (rnd_ff),
      .cipher    (cipher)
   );

   // Search sequencer and result register
   always_comb begin
      state_in  = state_ff;
      pt_in     = pt_ff;
      ct_in     = ct_ff;
      base_in   = base_ff;
      trial_in  = trial_ff;
      rnd_in    = rnd_ff;
      hit_in    = hit_ff;
      ovalid_in = ovalid_ff;
      okey_in   = okey_ff;
      ofound_in = ofound_ff;
      load      = 1'b0;
      req_stall = (state_ff != ST_IDLE);
      if (ovalid_ff && !rsp_stall) ovalid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pt_in    = req_plaintext;
               ct_in    = req_ciphertext;
               base_in  = base_key(req_round_subkey);
               trial_in = '0;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            load     = 1'b1;
            rnd_in   = 4'd1;
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (rnd_ff == 4'd0) begin
               // all 16 rounds done: compare
               if (cipher == ct_ff || trial_ff == '1) begin
                  hit_in   = (cipher == ct_ff);
                  state_in = ST_DONE;
               end else begin
                  trial_in = trial_ff + 1'b1;
                  state_in = ST_LOAD;
               end
            end else begin
               rnd_in = rnd_ff + 1'b1;
            end
         end
         ST_DONE: begin
            // candidate stays put here; load it once the output is free
            if (!ovalid_ff || !rsp_stall) begin
               okey_in   = odd_par(cand);
               ofound_in = hit_ff;
               ovalid_in = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ovalid_ff <= 1'b0;
         rnd_ff    <= '0;
         trial_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         ovalid_ff <= ovalid_in;
         rnd_ff    <= rnd_in;
         trial_ff  <= trial_in;
      end
   end

   always_ff @(posedge clock) begin
      pt_ff     <= pt_in;
      ct_ff     <= ct_in;
      base_ff   <= base_in;
      hit_ff    <= hit_in;
      okey_ff   <= okey_in;
      ofound_ff <= ofound_in;
   end

   assign rsp_valid    = ovalid_ff;
   assign rsp_full_key = okey_ff;
   assign rsp_found    = ofound_ff;

endmodule
`default_nettype wire
